### hdl/swpm_pkg.sv
`default_nettype none
package swpm_pkg;
    localparam int WINDOW_DEF = 1024;
    localparam int QW = 17;
    localparam int FW = 11;
    localparam int TW = 32;
    localparam logic [QW-1:0] PREC_FLOOR_RST = 17'd62259;
    localparam logic [QW-1:0] FP_CEIL_RST = 17'd1966;
    localparam logic [QW-1:0] DUP_ALERT_RST = 17'd13107;
    localparam logic [FW-1:0] MIN_SAMPLES_RST = 11'd50;

    typedef enum logic [1:0] {
        REG_PREC_FLOOR = 2'd0,
        REG_FP_CEIL    = 2'd1,
        REG_DUP_ALERT  = 2'd2,
        REG_MIN_SAMP   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CODE_NONE   = 2'd0,
        CODE_LOCK   = 2'd1,
        CODE_FORCEA = 2'd2
    } t_code;

    typedef struct packed {
        logic [QW-1:0] precision_ratio;
        logic [QW-1:0] recall_ratio;
        logic [QW-1:0] false_pos_ratio;
        logic [QW-1:0] duplicate_ratio;
        logic [QW-1:0] rejection_ratio;
        logic [FW-1:0] window_fill;
        logic [TW-1:0] total_count;
        logic [1:0]    containment_code;
        logic          prec_breach;
        logic          fp_breach;
        logic          dup_alarm;
        logic          contain_on;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic       rd;       // issue ring read at write pointer
        logic       update;   // retire and count new outcome
        logic       div_go;   // start a divide
        logic [2:0] div_sel;  // which ratio
        logic       div_save; // store quotient
        logic       cmp_go;   // breach compare step
        logic [1:0] cmp_sel;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;
endpackage
`default_nettype wire

### hdl/swpm_if.sv
`default_nettype none
interface swpm_in_if;
    logic valid;
    logic ready;
    logic pred_pos;
    logic truth_pos;
    logic dup_flag;
    logic rej_flag;
    modport source(output valid, pred_pos, truth_pos, dup_flag, rej_flag, input ready);
    modport sink(input valid, pred_pos, truth_pos, dup_flag, rej_flag, output ready);
endinterface

interface swpm_out_if;
    logic valid;
    logic ready;
    swpm_pkg::t_result data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface swpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;
    modport source(output valid, index, wdata, input ready);
    modport sink(input valid, index, wdata, output ready);
endinterface
`default_nettype wire

### hdl/swpm_ram.sv
`default_nettype none
module swpm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hdl/swpm_div.sv
`default_nettype none
module swpm_div #(
    parameter int CW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [CW-1:0] i_num,
    input  wire logic [CW-1:0] i_den,
    output logic               o_busy,
    output logic [CW+16-1:0]   o_quo
);
    localparam int NW = CW + 16;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_den;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic [CW:0]   n_shift;
    logic [CW:0]   n_diff;

    assign n_shift = {r_rem[CW-1:0], r_num[NW-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= SW'(NW);
            r_num  <= {i_num, 16'd0};
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!n_diff[CW]) begin
                r_rem <= n_diff;
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_num <= {r_num[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == SW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = (r_den == '0) ? '0 : r_num;
endmodule
`default_nettype wire

### hdl/swpm_datapath.sv
`default_nettype none
module swpm_datapath #(
    parameter int WINDOW = swpm_pkg::WINDOW_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire swpm_pkg::t_cmd      i_cmd,
    output swpm_pkg::t_sts           o_sts,
    input  wire logic [3:0]          i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    output swpm_pkg::t_result        o_res
);
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int QW = swpm_pkg::QW;
    localparam int FW = swpm_pkg::FW;
    localparam int PW = CW + QW;

    logic [QW-1:0] r_prec_floor, r_fp_ceil, r_dup_alert;
    logic [FW-1:0] r_min_samp;
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_fill, r_tp, r_fp, r_tn, r_fn, r_dup, r_rej;
    logic [31:0]   r_total;
    logic [3:0]    r_item;
    logic [3:0]    n_old;
    logic [CW-1:0] n_fill;
    logic [CW-1:0] n_tp, n_fp, n_tn, n_fn, n_dup, n_rej;
    logic          n_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec_floor <= swpm_pkg::PREC_FLOOR_RST;
            r_fp_ceil    <= swpm_pkg::FP_CEIL_RST;
            r_dup_alert  <= swpm_pkg::DUP_ALERT_RST;
            r_min_samp   <= swpm_pkg::MIN_SAMPLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swpm_pkg::REG_PREC_FLOOR: r_prec_floor <= i_cfg_data[QW-1:0];
                swpm_pkg::REG_FP_CEIL:    r_fp_ceil    <= i_cfg_data[QW-1:0];
                swpm_pkg::REG_DUP_ALERT:  r_dup_alert  <= i_cfg_data[QW-1:0];
                swpm_pkg::REG_MIN_SAMP:   r_min_samp   <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // outcome ring
    swpm_ram #(.WIDTH(4), .DEPTH(WINDOW)) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_waddr(r_wp),
        .i_wdata(r_item),
        .i_re   (i_cmd.rd),
        .i_raddr(r_wp),
        .o_rdata(n_old)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_item <= i_item;
        end
    end

    // retire oldest and count the new outcome
    assign n_full = (r_fill == CW'(WINDOW));
    always_comb begin
        n_tp  = r_tp;
        n_fp  = r_fp;
        n_tn  = r_tn;
        n_fn  = r_fn;
        n_dup = r_dup;
        n_rej = r_rej;
        n_fill = r_fill;
        if (n_full) begin
            case (n_old[1:0])
                2'b11:   if (n_tp != '0) n_tp = n_tp - 1'b1;
                2'b01:   if (n_fp != '0) n_fp = n_fp - 1'b1;
                2'b10:   if (n_fn != '0) n_fn = n_fn - 1'b1;
                default: if (n_tn != '0) n_tn = n_tn - 1'b1;
            endcase
            if (n_old[2] && n_dup != '0) n_dup = n_dup - 1'b1;
            if (n_old[3] && n_rej != '0) n_rej = n_rej - 1'b1;
        end else begin
            n_fill = r_fill + 1'b1;
        end
        case (r_item[1:0])
            2'b11:   n_tp = n_tp + 1'b1;
            2'b01:   n_fp = n_fp + 1'b1;
            2'b10:   n_fn = n_fn + 1'b1;
            default: n_tn = n_tn + 1'b1;
        endcase
        if (r_item[2]) n_dup = n_dup + 1'b1;
        if (r_item[3]) n_rej = n_rej + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_fill <= '0; r_tp <= '0; r_fp <= '0; r_tn <= '0;
            r_fn <= '0; r_dup <= '0; r_rej <= '0; r_total <= '0;
        end else if (i_cmd.update) begin
            r_wp    <= (r_wp == AW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
            r_fill  <= n_fill;
            r_tp <= n_tp; r_fp <= n_fp; r_tn <= n_tn; r_fn <= n_fn;
            r_dup <= n_dup; r_rej <= n_rej;
            r_total <= r_total + 1'b1;
        end
    end

    // shared divider operand select
    logic [CW-1:0]   n_pp, n_ap;
    logic [QW-1:0]   n_num, n_den;
    logic [QW+15:0]  w_quo;
    assign n_pp = r_tp + r_fp;
    assign n_ap = r_tp + r_fn;
    always_comb begin
        case (i_cmd.div_sel)
            3'd0:    begin n_num = QW'(r_tp);  n_den = QW'(n_pp);   end
            3'd1:    begin n_num = QW'(r_tp);  n_den = QW'(n_ap);   end
            3'd2:    begin n_num = QW'(r_fp);  n_den = QW'(n_pp);   end
            3'd3:    begin n_num = QW'(r_dup); n_den = QW'(r_fill); end
            default: begin n_num = QW'(r_rej); n_den = QW'(r_fill); end
        endcase
    end

    swpm_div #(.CW(QW)) u_div (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_go  (i_cmd.div_go),
        .i_num (n_num),
        .i_den (n_den),
        .o_busy(o_sts.div_busy),
        .o_quo (w_quo)
    );

    logic [QW-1:0] r_q [5];
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_save) begin
            r_q[i_cmd.div_sel] <= w_quo[QW-1:0];
        end
    end

    // breach compares, one cross product per step
    logic [PW-1:0]   n_prod;
    logic [CW+15:0]  n_lhs;
    logic [PW-1:0]   n_lhs_x;
    logic            r_prec_b, r_fp_b, r_dup_s, r_prec_raw;
    logic            n_enough;
    always_comb begin
        case (i_cmd.cmp_sel)
            2'd0:    begin n_prod = r_prec_floor * n_pp; n_lhs = {r_tp, 16'd0};  end
            2'd1:    begin n_prod = r_fp_ceil * n_pp;    n_lhs = {r_fp, 16'd0};  end
            default: begin n_prod = r_dup_alert * r_fill; n_lhs = {r_dup, 16'd0}; end
        endcase
    end
    assign n_lhs_x  = PW'(n_lhs);
    assign n_enough = (FW'(r_fill) >= r_min_samp) || (CW > FW && r_fill >= CW'(2048));

    // no predicted positives reads as zero precision
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_go) begin
            case (i_cmd.cmp_sel)
                2'd0:    r_prec_b <= n_enough && ((n_pp == '0) ? (r_prec_floor != '0) :
                                                                 (n_lhs_x < n_prod));
                2'd1:    r_fp_b   <= n_enough && (n_pp != '0) && (n_lhs_x > n_prod);
                default: r_dup_s  <= n_lhs_x > n_prod;
            endcase
        end
    end
    assign r_prec_raw = r_prec_b;

    always_comb begin
        o_res.precision_ratio  = r_q[0];
        o_res.recall_ratio     = r_q[1];
        o_res.false_pos_ratio  = r_q[2];
        o_res.duplicate_ratio  = r_q[3];
        o_res.rejection_ratio  = r_q[4];
        o_res.window_fill      = FW'(r_fill);
        o_res.total_count      = r_total;
        o_res.prec_breach      = r_prec_raw;
        o_res.fp_breach        = r_fp_b;
        o_res.dup_alarm        = r_dup_s;
        o_res.containment_code = r_prec_raw ? swpm_pkg::CODE_FORCEA :
                                 (r_fp_b ? swpm_pkg::CODE_LOCK : swpm_pkg::CODE_NONE);
        o_res.contain_on       = r_prec_raw | r_fp_b;
    end
endmodule
`default_nettype wire

### hdl/swpm_ctrl.sv
`default_nettype none
module swpm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire swpm_pkg::t_sts i_sts,
    output swpm_pkg::t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_UPD, S_DIV, S_WAIT, S_CMP, S_OUT
    } t_state;

    t_state     r_state;
    logic [2:0] r_idx;
    logic       r_kick;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.update   = (r_state == S_UPD);
        o_cmd.div_go   = (r_state == S_DIV);
        o_cmd.div_sel  = r_idx;
        o_cmd.div_save = (r_state == S_WAIT) && !r_kick && !i_sts.div_busy;
        o_cmd.cmp_go   = (r_state == S_CMP);
        o_cmd.cmp_sel  = r_idx[1:0];
    end

    // sequence: read ring, update, five divides, three compares, hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_kick  <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_RD;
                S_RD:   r_state <= S_UPD;
                S_UPD:  begin r_state <= S_DIV; r_idx <= '0; end
                S_DIV:  begin r_state <= S_WAIT; r_kick <= 1'b1; end
                S_WAIT: begin
                    if (!r_kick && !i_sts.div_busy) begin
                        if (r_idx == 3'd4) begin
                            r_state <= S_CMP;
                            r_idx   <= '0;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_CMP: begin
                    if (r_idx == 3'd2) r_state <= S_OUT;
                    else r_idx <= r_idx + 1'b1;
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/sliding_window_precision_monitor.sv
`default_nettype none
// one item at a time, the next accepted only once the result is taken: ring read
// and update, then five ratios through a shared 33-step divider, then three
// breach compares; a held result stalls the next word until taken
// synchronous active-low reset clears counters, pointer, configuration registers
// and controller state; the ring and the result registers are not cleared
module sliding_window_precision_monitor #(
    parameter int WINDOW = swpm_pkg::WINDOW_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    swpm_in_if.sink   in_ch,
    swpm_out_if.source out_ch,
    swpm_cfg_if.sink  cfg
);
    swpm_pkg::t_cmd w_cmd;
    swpm_pkg::t_sts w_sts;

    assign cfg.ready = 1'b1;

    swpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    swpm_datapath #(.WINDOW(WINDOW)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_item    ({in_ch.rej_flag, in_ch.dup_flag, in_ch.truth_pos, in_ch.pred_pos}),
        .i_cfg_we  (cfg.valid),
        .i_cfg_idx (cfg.index),
        .i_cfg_data(cfg.wdata),
        .o_res     (out_ch.data)
    );
endmodule
`default_nettype wire
